// ===== hdl/wpe_pkg.sv =====
// ----------------------------------------------------------------------------
// wpe_pkg
// Shared types and constants of the window point extraction block: field
// widths, configuration register indexes and the beat structs of both channels.
// ----------------------------------------------------------------------------
`default_nettype none

package wpe_pkg;

	// field widths
	localparam int COORD_WIDTH = 24;
	localparam int HALF_WIDTH  = COORD_WIDTH - 1;
	localparam int SEQ_WIDTH   = 20;
	localparam int ATTR_WIDTH  = 24;
	localparam int TRIG_WIDTH  = 16;
	localparam int TRIG_FRAC   = 14;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = (COORD_WIDTH > TRIG_WIDTH) ? COORD_WIDTH : TRIG_WIDTH;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_CENTER_X    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_COS_HEADING = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SIN_HEADING = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_HALF_WIDTH  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_HALF_HEIGHT = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_OFFSET_X    = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Y    = 3'd7;

	// cosine reset value, 1.0 in Q2.14
	localparam logic signed [TRIG_WIDTH-1:0] COS_RESET = 16'sd16384;

	typedef struct packed {
		logic        [SEQ_WIDTH-1:0]   seq_id;
		logic signed [COORD_WIDTH-1:0] pos_x;
		logic signed [COORD_WIDTH-1:0] pos_y;
		logic                          goal_flag;
		logic signed [ATTR_WIDTH-1:0]  point_heading;
		logic signed [ATTR_WIDTH-1:0]  point_velocity;
	} in_item_t;

	typedef struct packed {
		logic                          inside_res;
		logic        [SEQ_WIDTH-1:0]   out_seq_id;
		logic signed [COORD_WIDTH-1:0] local_x;
		logic signed [COORD_WIDTH-1:0] local_y;
		logic                          out_goal_flag;
		logic signed [ATTR_WIDTH-1:0]  out_heading;
		logic signed [ATTR_WIDTH-1:0]  out_velocity;
	} out_item_t;

	typedef struct packed {
		logic signed [COORD_WIDTH-1:0] center_x;
		logic signed [COORD_WIDTH-1:0] center_y;
		logic signed [TRIG_WIDTH-1:0]  cos_heading;
		logic signed [TRIG_WIDTH-1:0]  sin_heading;
		logic        [HALF_WIDTH-1:0]  half_width;
		logic        [HALF_WIDTH-1:0]  half_height;
		logic signed [COORD_WIDTH-1:0] offset_x;
		logic signed [COORD_WIDTH-1:0] offset_y;
	} cfg_t;

endpackage

`default_nettype wire

// ===== hdl/wpe_cfg.sv =====
// ----------------------------------------------------------------------------
// wpe_cfg
// Configuration register bank: decodes the write port and holds the window
// pose, box size and robot offset.
// ----------------------------------------------------------------------------
`default_nettype none

module wpe_cfg (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 cfg_wr_en,
	input  wire  [wpe_pkg::CFG_IDX_W-1:0]       cfg_idx,
	input  wire  [wpe_pkg::CFG_DATA_W-1:0]      cfg_wdata,
	output wpe_pkg::cfg_t                       cfg
);
	import wpe_pkg::*;

	cfg_t cfg_q;

	// register writes, unknown indexes ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.center_x    <= '0;
			cfg_q.center_y    <= '0;
			cfg_q.cos_heading <= COS_RESET;
			cfg_q.sin_heading <= '0;
			cfg_q.half_width  <= '0;
			cfg_q.half_height <= '0;
			cfg_q.offset_x    <= '0;
			cfg_q.offset_y    <= '0;
		end else if (cfg_wr_en) begin
			unique case (cfg_idx)
				REG_CENTER_X:    cfg_q.center_x    <= cfg_wdata[COORD_WIDTH-1:0];
				REG_CENTER_Y:    cfg_q.center_y    <= cfg_wdata[COORD_WIDTH-1:0];
				REG_COS_HEADING: cfg_q.cos_heading <= cfg_wdata[TRIG_WIDTH-1:0];
				REG_SIN_HEADING: cfg_q.sin_heading <= cfg_wdata[TRIG_WIDTH-1:0];
				REG_HALF_WIDTH:  cfg_q.half_width  <= cfg_wdata[HALF_WIDTH-1:0];
				REG_HALF_HEIGHT: cfg_q.half_height <= cfg_wdata[HALF_WIDTH-1:0];
				REG_OFFSET_X:    cfg_q.offset_x    <= cfg_wdata[COORD_WIDTH-1:0];
				REG_OFFSET_Y:    cfg_q.offset_y    <= cfg_wdata[COORD_WIDTH-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

// ===== hdl/window_point_extract_top.sv =====
// ----------------------------------------------------------------------------
// window_point_extract_top
// Moves path points into a window frame, tests them against the window box
// and subtracts the robot offset.
// ----------------------------------------------------------------------------
// Usage:
//   in channel: one path point per beat (in_valid/in_ready, in_data).
//   out channel: one result per point, in order (out_valid/out_ready,
//   out_data), with the inside flag, shifted local coordinates and the
//   attributes copied through.
//   cfg port: write-only register bank, one register per cycle while
//   cfg_wr_en is high; write only while no point is in flight.
// Pipeline: difference, products, round and saturate, box test and offset
//   stages, each registered.
// Throughput: one point per cycle while out_ready is not held low; each of
//   the four stages holds one point and has its own valid bit.
// Stall: when out_ready is low the last stage holds its beat and the stages
//   behind it keep filling; in_ready drops only once all four are full.
// Reset: pipeline empties, registers return to center 0, heading 0 (cos 1.0),
//   zero box size and zero offset.
// ----------------------------------------------------------------------------
`default_nettype none

module window_point_extract_top (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 in_valid,
	output logic                                in_ready,
	input  wire  wpe_pkg::in_item_t             in_data,
	output logic                                out_valid,
	input  wire                                 out_ready,
	output wpe_pkg::out_item_t                  out_data,
	input  wire                                 cfg_wr_en,
	input  wire  [wpe_pkg::CFG_IDX_W-1:0]       cfg_idx,
	input  wire  [wpe_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
	import wpe_pkg::*;

	localparam int DW = COORD_WIDTH + 1;            // difference width
	localparam int PW = TRIG_WIDTH + DW;            // product width
	localparam int SW = PW + 2;                     // sum width with rounding
	localparam int QW = SW - TRIG_FRAC;             // width after the shift
	localparam logic signed [SW-1:0] RND = SW'(1) <<< (TRIG_FRAC - 1);
	localparam logic signed [COORD_WIDTH-1:0] C_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
	localparam logic signed [COORD_WIDTH-1:0] C_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

	cfg_t cfg;

	wpe_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	// stage valids and per-stage ready chain
	logic v_s1, v_s2, v_s3, v_s4;
	logic rdy1, rdy2, rdy3, rdy4;

	assign rdy4     = !v_s4 || out_ready;
	assign rdy3     = !v_s3 || rdy4;
	assign rdy2     = !v_s2 || rdy3;
	assign rdy1     = !v_s1 || rdy2;
	assign in_ready = rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= in_valid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) v_s4 <= v_s3;
		end
	end

	// stage 1: difference to the window center, full precision
	in_item_t                item_s1;
	logic signed [DW-1:0]    dx_s1, dy_s1;

	always_ff @(posedge clk) begin
		if (rdy1 && in_valid) begin
			item_s1 <= in_data;
			dx_s1   <= {in_data.pos_x[COORD_WIDTH-1], in_data.pos_x}
			         - {cfg.center_x[COORD_WIDTH-1], cfg.center_x};
			dy_s1   <= {in_data.pos_y[COORD_WIDTH-1], in_data.pos_y}
			         - {cfg.center_y[COORD_WIDTH-1], cfg.center_y};
		end
	end

	// stage 2: the four rotation products
	in_item_t                item_s2;
	logic signed [PW-1:0]    p_cdx_s2, p_sdy_s2, p_cdy_s2, p_sdx_s2;

	always_ff @(posedge clk) begin
		if (rdy2 && v_s1) begin
			item_s2  <= item_s1;
			p_cdx_s2 <= cfg.cos_heading * dx_s1;
			p_sdy_s2 <= cfg.sin_heading * dy_s1;
			p_cdy_s2 <= cfg.cos_heading * dy_s1;
			p_sdx_s2 <= cfg.sin_heading * dx_s1;
		end
	end

	// stage 3: sum, round half up to Q8.16, saturate
	logic signed [SW-1:0]          sum_x, sum_y;
	logic        [QW-1:0]          q_x, q_y;
	logic signed [COORD_WIDTH-1:0] rx_n, ry_n;

	always_comb begin
		sum_x = SW'(p_cdx_s2) + SW'(p_sdy_s2) + RND;
		sum_y = SW'(p_cdy_s2) - SW'(p_sdx_s2) + RND;
		q_x   = sum_x[SW-1:TRIG_FRAC];
		q_y   = sum_y[SW-1:TRIG_FRAC];
		if ((&q_x[QW-1:COORD_WIDTH-1]) || !(|q_x[QW-1:COORD_WIDTH-1]))
			rx_n = q_x[COORD_WIDTH-1:0];
		else
			rx_n = q_x[QW-1] ? C_MIN : C_MAX;
		if ((&q_y[QW-1:COORD_WIDTH-1]) || !(|q_y[QW-1:COORD_WIDTH-1]))
			ry_n = q_y[COORD_WIDTH-1:0];
		else
			ry_n = q_y[QW-1] ? C_MIN : C_MAX;
	end

	in_item_t                      item_s3;
	logic signed [COORD_WIDTH-1:0] rx_s3, ry_s3;

	always_ff @(posedge clk) begin
		if (rdy3 && v_s2) begin
			item_s3 <= item_s2;
			rx_s3   <= rx_n;
			ry_s3   <= ry_n;
		end
	end

	// stage 4: inclusive box test and offset subtraction with saturation
	logic signed [DW-1:0]          rxe, rye, hh, hw, lx_d, ly_d;
	logic                          inside_n;
	logic signed [COORD_WIDTH-1:0] lx_n, ly_n;

	always_comb begin
		rxe      = {rx_s3[COORD_WIDTH-1], rx_s3};
		rye      = {ry_s3[COORD_WIDTH-1], ry_s3};
		hh       = {2'b00, cfg.half_height};
		hw       = {2'b00, cfg.half_width};
		inside_n = (rxe <= hh) && (rxe >= -hh) && (rye <= hw) && (rye >= -hw);
		lx_d     = rxe - {cfg.offset_x[COORD_WIDTH-1], cfg.offset_x};
		ly_d     = rye - {cfg.offset_y[COORD_WIDTH-1], cfg.offset_y};
		if (lx_d[DW-1] == lx_d[DW-2])
			lx_n = lx_d[COORD_WIDTH-1:0];
		else
			lx_n = lx_d[DW-1] ? C_MIN : C_MAX;
		if (ly_d[DW-1] == ly_d[DW-2])
			ly_n = ly_d[COORD_WIDTH-1:0];
		else
			ly_n = ly_d[DW-1] ? C_MIN : C_MAX;
	end

	out_item_t out_s4;

	always_ff @(posedge clk) begin
		if (rdy4 && v_s3) begin
			out_s4.inside_res    <= inside_n;
			out_s4.out_seq_id    <= item_s3.seq_id;
			out_s4.local_x       <= lx_n;
			out_s4.local_y       <= ly_n;
			out_s4.out_goal_flag <= item_s3.goal_flag;
			out_s4.out_heading   <= item_s3.point_heading;
			out_s4.out_velocity  <= item_s3.point_velocity;
		end
	end

	assign out_valid = v_s4;
	assign out_data  = out_s4;

	// input backpressure only when every stage holds a beat
	a_full_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (v_s1 && v_s2 && v_s3 && v_s4))
		else $error("in_ready low with an empty stage");

	// a held round-and-saturate stage keeps its values
	a_s3_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s3 && !rdy3) |=> (v_s3 && $stable(rx_s3) && $stable(ry_s3)))
		else $error("stage 3 changed while stalled");

	// with zero offset a kept point lies within the box bounds
	a_inside_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s4 && out_s4.inside_res && cfg.offset_x == '0 && cfg.offset_y == '0)
		|-> ((DW'(out_s4.local_x) <= hh) && (DW'(out_s4.local_x) >= -hh)
		&& (DW'(out_s4.local_y) <= hw) && (DW'(out_s4.local_y) >= -hw)))
		else $error("inside flag set for a point outside the box");

	// a beat moves into an empty stage 4 whenever stage 3 holds one
	a_s4_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s3 && !v_s4) |=> v_s4)
		else $error("stage 4 failed to take a waiting beat");

endmodule

`default_nettype wire
